/* design/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers used by binary_max_heap_queue.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check prop at every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check that cause implies effect in the same cycle
`define ASSERT_IMPL(label, cause, effect, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cause) |-> (effect)) \
    else $error(msg);

`endif

/* design/bmhq_pkg.sv */
// ---------------------------------------------------------------------------
// bmhq_pkg
// Shared constants, types and codes of the binary max-heap queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package bmhq_pkg;

  localparam int CAPACITY  = 64;
  localparam int KEY_BITS  = 32;
  localparam int DATA_BITS = 32;

  localparam int IDX_W   = $clog2(CAPACITY);
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int CHILD_W = IDX_W + 2;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef struct packed {
    logic [KEY_BITS-1:0]  key;
    logic [DATA_BITS-1:0] payload;
  } entry_t;

  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr_a;
    logic [IDX_W-1:0] rd_addr_b;
  } mem_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP_CHK,
    ST_UP_CMP,
    ST_DN_RD,
    ST_DN_LD,
    ST_DN_CHK,
    ST_DN_CMP
  } state_t;

endpackage

/* design/bmhq_mem.sv */
// ---------------------------------------------------------------------------
// bmhq_mem
// Heap entry store: one write port, two registered read ports.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bmhq_mem (
  input  logic               clk,
  input  bmhq_pkg::mem_req_t req,
  output bmhq_pkg::entry_t   rd_data_a,
  output bmhq_pkg::entry_t   rd_data_b
);

  bmhq_pkg::entry_t mem [bmhq_pkg::CAPACITY];
  bmhq_pkg::entry_t rd_a_r;
  bmhq_pkg::entry_t rd_b_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_a_r <= mem[req.rd_addr_a];
      rd_b_r <= mem[req.rd_addr_b];
    end
  end

  assign rd_data_a = rd_a_r;
  assign rd_data_b = rd_b_r;

endmodule

/* design/binary_max_heap_queue.sv */
// ---------------------------------------------------------------------------
// binary_max_heap_queue
// Max-heap priority queue of key/payload entries kept in an on-chip store.
//
//   channel   ports                                     handshake
//   input     in_operation, in_key, in_payload          start && !busy
//   result    out_ok, out_key, out_payload, out_is_empty out_valid, one cycle
//
// Insert: the entry climbs from the new last slot to the root or until a
// compare stops it. Remove: reads the root and last entries, ends if the heap
// empties, else descends until no left child remains or a compare stops it.
// Refused requests finish in the accept cycle; the result strobe rises in the
// cycle after the last step. Each level costs one store read and one
// compare/write-back. Reset empties the heap at once; results cannot stall.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module binary_max_heap_queue (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_operation,
  input  logic [bmhq_pkg::KEY_BITS-1:0]  in_key,
  input  logic [bmhq_pkg::DATA_BITS-1:0] in_payload,
  output logic                           out_valid,
  output logic                           out_ok,
  output logic [bmhq_pkg::KEY_BITS-1:0]  out_key,
  output logic [bmhq_pkg::DATA_BITS-1:0] out_payload,
  output logic                           out_is_empty
);

  bmhq_pkg::state_t state_r, state_nxt;
  logic [bmhq_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [bmhq_pkg::IDX_W-1:0] pos_r, pos_nxt;
  bmhq_pkg::entry_t mov_r, mov_nxt;
  bmhq_pkg::entry_t res_r, res_nxt;

  logic                           out_valid_r, out_valid_nxt;
  logic                           out_ok_r, out_ok_nxt;
  logic [bmhq_pkg::KEY_BITS-1:0]  out_key_r, out_key_nxt;
  logic [bmhq_pkg::DATA_BITS-1:0] out_payload_r, out_payload_nxt;
  logic                           out_is_empty_r, out_is_empty_nxt;

  bmhq_pkg::mem_req_t mem_req;
  bmhq_pkg::entry_t   rd_a;
  bmhq_pkg::entry_t   rd_b;

  logic                         fin;
  logic                         fin_ok;
  logic                         accept;
  logic [bmhq_pkg::IDX_W-1:0]   par_idx;
  logic [bmhq_pkg::IDX_W:0]     pos_p1;
  logic [bmhq_pkg::CHILD_W-1:0] lc_idx;
  logic [bmhq_pkg::CHILD_W-1:0] rc_idx;
  logic [bmhq_pkg::CHILD_W-1:0] cnt_ext;
  logic                         has_left;
  logic                         pick_right;
  bmhq_pkg::entry_t             pick_ent;
  logic [bmhq_pkg::IDX_W-1:0]   pick_idx;
  logic                         up_swap;
  logic                         dn_swap;
  logic                         wr_in_range;

  bmhq_mem u_mem (
    .clk       (clk),
    .req       (mem_req),
    .rd_data_a (rd_a),
    .rd_data_b (rd_b)
  );

  assign busy   = (state_r != bmhq_pkg::ST_IDLE);
  assign accept = start && !busy;

  assign par_idx  = (pos_r - 1'b1) >> 1;
  assign pos_p1   = {1'b0, pos_r} + 1'b1;
  assign lc_idx   = {1'b0, pos_r, 1'b1};
  assign rc_idx   = {pos_p1, 1'b0};
  assign cnt_ext  = {{(bmhq_pkg::CHILD_W - bmhq_pkg::CNT_W){1'b0}}, count_r};
  assign has_left = (lc_idx < cnt_ext);

  assign pick_right = (rc_idx < cnt_ext) && (rd_b.key > rd_a.key);
  assign pick_ent   = pick_right ? rd_b : rd_a;
  assign pick_idx   = pick_right ? rc_idx[bmhq_pkg::IDX_W-1:0] : lc_idx[bmhq_pkg::IDX_W-1:0];
  assign up_swap    = (mov_r.key > rd_a.key);
  assign dn_swap    = (pick_ent.key > mov_r.key);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bmhq_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_operation == bmhq_pkg::OP_INSERT) begin
            if (count_r != bmhq_pkg::CAP_CNT) state_nxt = bmhq_pkg::ST_UP_CHK;
          end else begin
            if (count_r != '0) state_nxt = bmhq_pkg::ST_DN_RD;
          end
        end
      end
      bmhq_pkg::ST_UP_CHK: begin
        if (pos_r == '0) state_nxt = bmhq_pkg::ST_IDLE;
        else             state_nxt = bmhq_pkg::ST_UP_CMP;
      end
      bmhq_pkg::ST_UP_CMP: begin
        if (up_swap) state_nxt = bmhq_pkg::ST_UP_CHK;
        else         state_nxt = bmhq_pkg::ST_IDLE;
      end
      bmhq_pkg::ST_DN_RD: begin
        state_nxt = bmhq_pkg::ST_DN_LD;
      end
      bmhq_pkg::ST_DN_LD: begin
        if (count_r == '0) state_nxt = bmhq_pkg::ST_IDLE;
        else               state_nxt = bmhq_pkg::ST_DN_CHK;
      end
      bmhq_pkg::ST_DN_CHK: begin
        if (has_left) state_nxt = bmhq_pkg::ST_DN_CMP;
        else          state_nxt = bmhq_pkg::ST_IDLE;
      end
      bmhq_pkg::ST_DN_CMP: begin
        if (dn_swap) state_nxt = bmhq_pkg::ST_DN_CHK;
        else         state_nxt = bmhq_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = bmhq_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    mem_req   = '0;
    count_nxt = count_r;
    pos_nxt   = pos_r;
    mov_nxt   = mov_r;
    res_nxt   = res_r;
    fin       = 1'b0;
    fin_ok    = 1'b0;
    case (state_r)
      bmhq_pkg::ST_IDLE: begin
        if (accept) begin
          res_nxt = '0;
          if (in_operation == bmhq_pkg::OP_INSERT) begin
            if (count_r != bmhq_pkg::CAP_CNT) begin
              pos_nxt   = count_r[bmhq_pkg::IDX_W-1:0];
              count_nxt = count_r + 1'b1;
              mov_nxt   = '{key: in_key, payload: in_payload};
            end else begin
              fin = 1'b1;
            end
          end else begin
            if (count_r != '0) begin
              count_nxt = count_r - 1'b1;
              pos_nxt   = '0;
            end else begin
              fin = 1'b1;
            end
          end
        end
      end
      bmhq_pkg::ST_UP_CHK: begin
        if (pos_r == '0) begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = pos_r;
          mem_req.wr_data = mov_r;
          fin             = 1'b1;
          fin_ok          = 1'b1;
        end else begin
          mem_req.rd_en     = 1'b1;
          mem_req.rd_addr_a = par_idx;
          mem_req.rd_addr_b = par_idx;
        end
      end
      bmhq_pkg::ST_UP_CMP: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = pos_r;
        if (up_swap) begin
          mem_req.wr_data = rd_a;
          pos_nxt         = par_idx;
        end else begin
          mem_req.wr_data = mov_r;
          fin             = 1'b1;
          fin_ok          = 1'b1;
        end
      end
      bmhq_pkg::ST_DN_RD: begin
        mem_req.rd_en     = 1'b1;
        mem_req.rd_addr_a = '0;
        mem_req.rd_addr_b = count_r[bmhq_pkg::IDX_W-1:0];
      end
      bmhq_pkg::ST_DN_LD: begin
        res_nxt = rd_a;
        mov_nxt = rd_b;
        if (count_r == '0) begin
          fin    = 1'b1;
          fin_ok = 1'b1;
        end
      end
      bmhq_pkg::ST_DN_CHK: begin
        if (has_left) begin
          mem_req.rd_en     = 1'b1;
          mem_req.rd_addr_a = lc_idx[bmhq_pkg::IDX_W-1:0];
          mem_req.rd_addr_b = rc_idx[bmhq_pkg::IDX_W-1:0];
        end else begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = pos_r;
          mem_req.wr_data = mov_r;
          fin             = 1'b1;
          fin_ok          = 1'b1;
        end
      end
      bmhq_pkg::ST_DN_CMP: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = pos_r;
        if (dn_swap) begin
          mem_req.wr_data = pick_ent;
          pos_nxt         = pick_idx;
        end else begin
          mem_req.wr_data = mov_r;
          fin             = 1'b1;
          fin_ok          = 1'b1;
        end
      end
      default: begin
        mem_req = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt    = fin;
    out_ok_nxt       = out_ok_r;
    out_key_nxt      = out_key_r;
    out_payload_nxt  = out_payload_r;
    out_is_empty_nxt = out_is_empty_r;
    if (fin) begin
      out_ok_nxt       = fin_ok;
      out_key_nxt      = res_nxt.key;
      out_payload_nxt  = res_nxt.payload;
      out_is_empty_nxt = (count_nxt == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bmhq_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r          <= pos_nxt;
    mov_r          <= mov_nxt;
    res_r          <= res_nxt;
    out_ok_r       <= out_ok_nxt;
    out_key_r      <= out_key_nxt;
    out_payload_r  <= out_payload_nxt;
    out_is_empty_r <= out_is_empty_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_ok       = out_ok_r;
  assign out_key      = out_key_r;
  assign out_payload  = out_payload_r;
  assign out_is_empty = out_is_empty_r;

  assign wr_in_range = ({{(bmhq_pkg::CNT_W - bmhq_pkg::IDX_W){1'b0}}, mem_req.wr_addr} < count_r);

  `ASSERT_CLK(a_count_range, count_r <= bmhq_pkg::CAP_CNT, "entry count above capacity")
  `ASSERT_IMPL(a_result_idle, out_valid, !busy, "result strobe while sift in progress")
  `ASSERT_IMPL(a_write_live, mem_req.wr_en, wr_in_range, "store write beyond live entries")
  `ASSERT_IMPL(a_refuse_cause, out_valid && !out_ok,
    (out_is_empty && count_r == '0) || (!out_is_empty && count_r == bmhq_pkg::CAP_CNT),
    "refused request without full or empty heap")

endmodule

/* dv/heap_checker.sv */
// ---------------------------------------------------------------------------
// heap_checker
// Watches the request and result channels of the max-heap queue. Keeps its
// own copy of the heap, works out the result of every accepted request and
// compares each strobed result, field by field, with the oldest one due.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module heap_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic                           busy,
  input  logic                           in_operation,
  input  logic [bmhq_pkg::KEY_BITS-1:0]  in_key,
  input  logic [bmhq_pkg::DATA_BITS-1:0] in_payload,
  input  logic                           out_valid,
  input  logic                           out_ok,
  input  logic [bmhq_pkg::KEY_BITS-1:0]  out_key,
  input  logic [bmhq_pkg::DATA_BITS-1:0] out_payload,
  input  logic                           out_is_empty,
  output int                             mismatches,
  output int                             outstanding,
  output int                             entries_returned,
  output int                             refusals
);

  typedef struct packed {
    logic                           was_remove;
    logic                           ok;
    logic [bmhq_pkg::KEY_BITS-1:0]  key;
    logic [bmhq_pkg::DATA_BITS-1:0] payload;
    logic                           is_empty;
  } heap_result_t;

  bmhq_pkg::entry_t heap_slots [bmhq_pkg::CAPACITY];
  int               heap_size;
  heap_result_t     results_due [$];

  initial begin
    mismatches       = 0;
    outstanding      = 0;
    entries_returned = 0;
    refusals         = 0;
    heap_size        = 0;
  end

  function automatic void swap_slots(int a, int b);
    bmhq_pkg::entry_t tmp;
    tmp           = heap_slots[a];
    heap_slots[a] = heap_slots[b];
    heap_slots[b] = tmp;
  endfunction

  function automatic heap_result_t heap_apply(logic op, logic [bmhq_pkg::KEY_BITS-1:0] key,
                                              logic [bmhq_pkg::DATA_BITS-1:0] payload);
    heap_result_t res;
    int           pos;
    int           left;
    int           pick;
    res            = '0;
    res.was_remove = (op == bmhq_pkg::OP_REMOVE);
    if (op == bmhq_pkg::OP_INSERT) begin
      if (heap_size < bmhq_pkg::CAPACITY) begin
        pos                     = heap_size;
        heap_slots[pos].key     = key;
        heap_slots[pos].payload = payload;
        heap_size++;
        while (pos != 0 && heap_slots[pos].key > heap_slots[(pos - 1) / 2].key) begin
          swap_slots(pos, (pos - 1) / 2);
          pos = (pos - 1) / 2;
        end
        res.ok = 1'b1;
      end
    end else if (heap_size != 0) begin
      res.key       = heap_slots[0].key;
      res.payload   = heap_slots[0].payload;
      heap_slots[0] = heap_slots[heap_size - 1];
      heap_size--;
      pos  = 0;
      left = 1;
      while (left < heap_size) begin
        pick = left;
        if (left + 1 < heap_size && heap_slots[left + 1].key > heap_slots[left].key)
          pick = left + 1;
        if (heap_slots[pick].key > heap_slots[pos].key) begin
          swap_slots(pick, pos);
          pos  = pick;
          left = 2 * pos + 1;
        end else begin
          left = heap_size;
        end
      end
      res.ok = 1'b1;
    end
    res.is_empty = (heap_size == 0);
    return res;
  endfunction

  task automatic compare_field(string field, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    heap_result_t due;
    if (!rst_n) begin
      results_due.delete();
      heap_size = 0;
    end else begin
      // retire the strobed result before taking a new request in the same cycle
      if (out_valid) begin
        if (results_due.size() == 0) begin
          $error("result with no request pending: ok=%0b key=%0h payload=%0h",
                 out_ok, out_key, out_payload);
          mismatches++;
        end else begin
          due = results_due.pop_front();
          compare_field("out_ok", 64'(due.ok), 64'(out_ok));
          compare_field("out_key", 64'(due.key), 64'(out_key));
          compare_field("out_payload", 64'(due.payload), 64'(out_payload));
          compare_field("out_is_empty", 64'(due.is_empty), 64'(out_is_empty));
          if (!due.ok)
            refusals++;
          else if (due.was_remove)
            entries_returned++;
        end
      end
      if (start && !busy)
        results_due.push_back(heap_apply(in_operation, in_key, in_payload));
    end
    outstanding <= results_due.size();
  end

endmodule

/* dv/tb_binary_max_heap_queue.sv */
// ---------------------------------------------------------------------------
// tb_binary_max_heap_queue
// Drives insert and remove requests into the max-heap queue: a directed
// opening (empty remove, extreme keys and payloads, equal keys) followed by
// random episodes that fill the heap past full, drain it past empty or mix
// both, under three sender pacing phases. A checker beside the block
// predicts and compares every result; this module gives the verdict.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_binary_max_heap_queue;

  localparam int REQUEST_TARGET = 900;
  localparam int STALL_LIMIT    = 4000;
  localparam int DRAIN_CYCLES   = 24;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           start = 1'b0;
  logic                           busy;
  logic                           in_operation = bmhq_pkg::OP_INSERT;
  logic [bmhq_pkg::KEY_BITS-1:0]  in_key = '0;
  logic [bmhq_pkg::DATA_BITS-1:0] in_payload = '0;
  logic                           out_valid;
  logic                           out_ok;
  logic [bmhq_pkg::KEY_BITS-1:0]  out_key;
  logic [bmhq_pkg::DATA_BITS-1:0] out_payload;
  logic                           out_is_empty;

  int mismatches;
  int outstanding;
  int entries_returned;
  int refusals;
  int requests_sent = 0;
  int inserts_sent  = 0;
  int removes_sent  = 0;
  int stall_cycles  = 0;

  always #5 clk = ~clk;

  binary_max_heap_queue DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_operation (in_operation),
    .in_key       (in_key),
    .in_payload   (in_payload),
    .out_valid    (out_valid),
    .out_ok       (out_ok),
    .out_key      (out_key),
    .out_payload  (out_payload),
    .out_is_empty (out_is_empty)
  );

  heap_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_operation     (in_operation),
    .in_key           (in_key),
    .in_payload       (in_payload),
    .out_valid        (out_valid),
    .out_ok           (out_ok),
    .out_key          (out_key),
    .out_payload      (out_payload),
    .out_is_empty     (out_is_empty),
    .mismatches       (mismatches),
    .outstanding      (outstanding),
    .entries_returned (entries_returned),
    .refusals         (refusals)
  );

  task automatic send_request(logic op, logic [bmhq_pkg::KEY_BITS-1:0] key,
                              logic [bmhq_pkg::DATA_BITS-1:0] payload);
    int idle_pct;
    idle_pct = (requests_sent < 300) ? 26 : (requests_sent < 600) ? 63 : 0;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start        <= 1'b1;
    in_operation <= op;
    in_key       <= key;
    in_payload   <= payload;
    do @(posedge clk); while (busy);
    requests_sent++;
    if (op == bmhq_pkg::OP_INSERT) inserts_sent++;
    else removes_sent++;
  endtask

  function automatic logic [bmhq_pkg::KEY_BITS-1:0] pick_key(int key_class);
    logic [bmhq_pkg::KEY_BITS-1:0] key;
    case (key_class)
      0: key = $urandom;
      1: key = $urandom_range(7);
      default: begin
        case ($urandom_range(3))
          0: key = '0;
          1: key = '1;
          2: key = {1'b1, {(bmhq_pkg::KEY_BITS - 1){1'b0}}};
          default: key = {1'b0, {(bmhq_pkg::KEY_BITS - 1){1'b1}}};
        endcase
      end
    endcase
    return key;
  endfunction

  // watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("watchdog: no request or result for %0d cycles", STALL_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int  mode;
    int  episode_len;
    int  key_class;
    int  insert_pct;
    bit  first_episode;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed opening
    send_request(bmhq_pkg::OP_REMOVE, '0, '0);
    send_request(bmhq_pkg::OP_INSERT, '0, '0);
    send_request(bmhq_pkg::OP_INSERT, '1, '1);
    send_request(bmhq_pkg::OP_INSERT, 32'd5, 32'h5555_5555);
    send_request(bmhq_pkg::OP_INSERT, 32'd5, 32'hAAAA_AAAA);
    send_request(bmhq_pkg::OP_INSERT, 32'd5, 32'h0000_0001);
    send_request(bmhq_pkg::OP_INSERT, 32'h8000_0000, 32'h8000_0000);
    send_request(bmhq_pkg::OP_INSERT, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_request(bmhq_pkg::OP_INSERT, 32'd1, 32'h1234_5678);
    repeat (8) send_request(bmhq_pkg::OP_REMOVE, $urandom, $urandom);
    send_request(bmhq_pkg::OP_REMOVE, '1, '1);

    // random episodes: fill past full, drain past empty, or mix
    first_episode = 1'b1;
    while (requests_sent < REQUEST_TARGET) begin
      mode          = first_episode ? 0 : $urandom_range(2);
      episode_len   = first_episode ? 120 : $urandom_range(20, 140);
      key_class     = $urandom_range(2);
      insert_pct    = (mode == 0) ? 85 : (mode == 1) ? 15 : 50;
      first_episode = 1'b0;
      repeat (episode_len) begin
        if (requests_sent < REQUEST_TARGET) begin
          if ($urandom_range(99) < insert_pct)
            send_request(bmhq_pkg::OP_INSERT, pick_key(key_class), $urandom);
          else
            send_request(bmhq_pkg::OP_REMOVE, $urandom, $urandom);
        end
      end
    end
    start <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d requests: %0d inserts, %0d removes, under three pacing phases.",
             requests_sent, inserts_sent, removes_sent);
    $display("Heap returned %0d entries and refused %0d requests on full or empty.",
             entries_returned, refusals);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
